>>> hw/rtl/qou_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion orientation unit package
// Item types, operation kinds, sequencer states and product schedules.
// ----------------------------------------------------------------------------
package qou_pkg;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] op_real;
    logic signed [31:0] op_x;
    logic signed [31:0] op_y;
    logic signed [31:0] op_z;
    logic signed [31:0] step_scale;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_real;
    logic signed [31:0] out_i;
    logic signed [31:0] out_j;
    logic signed [31:0] out_k;
    logic [1:0]         row_index;
    logic signed [31:0] col_zero;
    logic signed [31:0] col_one;
    logic signed [31:0] col_two;
    logic               last;
  } out_t;

  localparam logic [2:0] K_LOAD     = 3'd0;
  localparam logic [2:0] K_MUL      = 3'd1;
  localparam logic [2:0] K_ROT      = 3'd2;
  localparam logic [2:0] K_INTEG    = 3'd3;
  localparam logic [2:0] K_NORM     = 3'd4;
  localparam logic [2:0] K_READ     = 3'd5;
  localparam logic [2:0] K_UNUSED_6 = 3'd6;
  localparam logic [2:0] K_UNUSED_7 = 3'd7;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_SCALE = 10'b00_0000_0010,
    S_HAM   = 10'b00_0000_0100,
    S_UPD   = 10'b00_0000_1000,
    S_SQ    = 10'b00_0001_0000,
    S_SQRT  = 10'b00_0010_0000,
    S_CHK   = 10'b00_0100_0000,
    S_DIV   = 10'b00_1000_0000,
    S_MAT   = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_t;

  // Hamilton product schedule: term t feeds output t/4
  localparam logic [1:0] HAM_A [16] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3,
                                        2'd0, 2'd2, 2'd3, 2'd1, 2'd0, 2'd3, 2'd1, 2'd2};
  localparam logic [1:0] HAM_B [16] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0, 2'd3, 2'd2,
                                        2'd2, 2'd0, 2'd1, 2'd3, 2'd3, 2'd0, 2'd2, 2'd1};
  localparam logic       HAM_NEG [16] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
                                          1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};

  // Matrix products: ii jj kk ij ik jk ri rj rk
  localparam int         MAT_N = 9;
  localparam logic [1:0] MAT_A [16] = '{2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd0, 2'd0,
                                        2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0};
  localparam logic [1:0] MAT_B [16] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3, 2'd1, 2'd2,
                                        2'd3, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0};

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> hw/rtl/quaternion_orientation_unit.sv
// ----------------------------------------------------------------------------
// Quaternion orientation unit
// Holds one orientation quaternion and emits it with its rotation matrix.
// ----------------------------------------------------------------------------
// Usage:
//   in channel   : in_valid / in_stall / in_data, one operation item.
//   out channel  : out_valid / out_stall / out_data, three row items per input
//                  item, row 0..2, last set on row 2.
//   cfg channel  : cfg_valid / cfg_ready / cfg_data writes the zero threshold;
//                  cfg_ready is always high.
//   One 32x32 multiplier with a registered product serves every product.
//   Normalize time is set by the 32-step square root loop and the bit-serial
//   divider, and the divider is skipped on a zero norm. Rows 1 and 2 follow
//   row 0 in order, each held while the output stalls; the next item is
//   taken only after row 2 is loaded.
//   in_stall is high from acceptance until row 2 enters the output register.
//   A stalled receiver holds the output register and the sequencer waits.
//   Reset sets the quaternion to one and the threshold to 64.
// ----------------------------------------------------------------------------
module quaternion_orientation_unit #(
  parameter int FRAC_BITS = 30
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  qou_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output qou_pkg::out_t  out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [29:0]    cfg_data
);
  import qou_pkg::*;

  localparam int CNT_MAX = (FRAC_BITS > 31) ? FRAC_BITS : 31;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);
  localparam logic signed [31:0] ONE_SAT =
    (FRAC_BITS >= 31) ? 32'sh7FFF_FFFF : 32'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0] cidx_r, cidx_nxt, row_r, row_nxt;
  logic [2:0] kind_r, kind_nxt;
  logic signed [31:0] q_r [4];
  logic signed [31:0] q_nxt [4];
  logic signed [31:0] opv_r [4];
  logic signed [31:0] opv_nxt [4];
  logic signed [31:0] scale_r, scale_nxt;
  logic signed [63:0] acc_r [4];
  logic signed [63:0] acc_nxt [4];
  logic signed [63:0] mt_r [MAT_N];
  logic signed [63:0] mt_nxt [MAT_N];
  logic signed [63:0] prod_r, prod_nxt;
  logic [63:0] sum_r, sum_nxt, sw_r, sw_nxt, sr_r, sr_nxt, bit_r, bit_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [FRAC_BITS:0] quo_r, quo_nxt;
  logic [29:0] thr_r, thr_nxt;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] term;
  logic [CNT_W-1:0] cm1;
  logic integ;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign term      = prod_r >>> FRAC_BITS;
  assign cm1       = cnt_r - 1'b1;
  assign integ     = (kind_r == K_INTEG);

  always_comb begin
    logic [1:0] ia, ib;
    ia = HAM_A[cnt_r[3:0]];
    ib = HAM_B[cnt_r[3:0]];
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SCALE: begin
        mul_a = opv_r[cnt_r[1:0] + 2'd1];
        mul_b = scale_r;
      end
      S_HAM: begin
        mul_a = integ ? opv_r[ia] : q_r[ia];
        mul_b = integ ? q_r[ib] : opv_r[ib];
      end
      S_SQ: begin
        mul_a = q_r[cnt_r[1:0]];
        mul_b = q_r[cnt_r[1:0]];
      end
      S_MAT: begin
        mul_a = q_r[MAT_A[cnt_r[3:0]]];
        mul_b = q_r[MAT_B[cnt_r[3:0]]];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  always_comb begin
    logic [64:0] sum_add, trial;
    logic [33:0] t;
    logic [33:0] nn;
    logic ge;
    logic signed [63:0] qv;
    logic [31:0] mg;
    logic signed [63:0] c0, c1, c2;
    logic [1:0] nidx;
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cidx_nxt = cidx_r;
    row_nxt = row_r;
    kind_nxt = kind_r;
    q_nxt = q_r;
    opv_nxt = opv_r;
    scale_nxt = scale_r;
    acc_nxt = acc_r;
    mt_nxt = mt_r;
    sum_nxt = sum_r;
    sw_nxt = sw_r;
    sr_nxt = sr_r;
    bit_nxt = bit_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    thr_nxt = thr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;
    sum_add = {1'b0, sum_r} + {1'b0, prod_r};
    trial = {1'b0, sr_r} + {1'b0, bit_r};
    nn = {2'b00, sr_r[31:0]};
    t = (cnt_r == '0) ? rem_r : {rem_r[32:0], 1'b0};
    ge = (t >= nn);
    qv = '0;
    mg = '0;
    nidx = cidx_r + 2'd1;
    c0 = '0;
    c1 = '0;
    c2 = '0;

    if (cfg_valid) thr_nxt = cfg_data;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_data.kind;
          opv_nxt[0] = (in_data.kind == K_ROT || in_data.kind == K_INTEG) ? '0 :
                       in_data.op_real;
          opv_nxt[1] = in_data.op_x;
          opv_nxt[2] = in_data.op_y;
          opv_nxt[3] = in_data.op_z;
          scale_nxt = in_data.step_scale;
          for (int k = 0; k < 4; k++) acc_nxt[k] = '0;
          sum_nxt = '0;
          cnt_nxt = '0;
          case (in_data.kind) inside
            K_LOAD: begin
              q_nxt[0] = in_data.op_real;
              q_nxt[1] = in_data.op_x;
              q_nxt[2] = in_data.op_y;
              q_nxt[3] = in_data.op_z;
              state_nxt = S_MAT;
            end
            K_MUL, K_ROT: state_nxt = S_HAM;
            K_INTEG:      state_nxt = S_SCALE;
            K_NORM:       state_nxt = S_SQ;
            default:      state_nxt = S_MAT;
          endcase
        end
      end
      S_SCALE: begin
        if (cnt_r != '0) opv_nxt[cnt_r[1:0]] = sat32(term);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(3)) begin
          cnt_nxt = '0;
          state_nxt = S_HAM;
        end
      end
      S_HAM: begin
        if (cnt_r != '0) begin
          if (HAM_NEG[cm1[3:0]]) acc_nxt[cm1[3:2]] = acc_r[cm1[3:2]] - term;
          else acc_nxt[cm1[3:2]] = acc_r[cm1[3:2]] + term;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(16)) begin
          cnt_nxt = '0;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        for (int k = 0; k < 4; k++) begin
          if (integ) q_nxt[k] = sat32(64'(q_r[k]) + (acc_r[k] >>> 1));
          else q_nxt[k] = sat32(acc_r[k]);
        end
        state_nxt = S_MAT;
      end
      S_SQ: begin
        if (cnt_r != '0) sum_nxt = sum_add[64] ? '1 : sum_add[63:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(4)) begin
          sw_nxt = sum_nxt;
          sr_nxt = '0;
          bit_nxt = 64'd1 << 62;
          cnt_nxt = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if ({1'b0, sw_r} >= trial) begin
          sw_nxt = sw_r - trial[63:0];
          sr_nxt = (sr_r >> 1) + bit_r;
        end else begin
          sr_nxt = sr_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(31)) state_nxt = S_CHK;
      end
      S_CHK: begin
        cnt_nxt = '0;
        if ((sum_r >> FRAC_BITS) <= {34'd0, thr_r} || sr_r == '0) begin
          q_nxt[0] = ONE_SAT;
          state_nxt = S_MAT;
        end else begin
          mg = q_r[0][31] ? 32'(-q_r[0]) : q_r[0];
          rem_nxt = {2'b00, mg};
          quo_nxt = '0;
          cidx_nxt = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = ge ? t - nn : t;
        quo_nxt = {quo_r[FRAC_BITS-1:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(FRAC_BITS)) begin
          qv = 64'(quo_nxt);
          q_nxt[cidx_r] = sat32(q_r[cidx_r][31] ? -qv : qv);
          cnt_nxt = '0;
          if (cidx_r == 2'd3) begin
            state_nxt = S_MAT;
          end else begin
            cidx_nxt = nidx;
            mg = q_r[nidx][31] ? 32'(-q_r[nidx]) : q_r[nidx];
            rem_nxt = {2'b00, mg};
            quo_nxt = '0;
          end
        end
      end
      S_MAT: begin
        if (cnt_r != '0) mt_nxt[cm1[3:0]] = term;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MAT_N)) begin
          cnt_nxt = '0;
          row_nxt = '0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        unique case (row_r)
          2'd0: begin
            c0 = ONE_Q - ((mt_r[1] + mt_r[2]) <<< 1);
            c1 = (mt_r[3] + mt_r[8]) <<< 1;
            c2 = (mt_r[4] - mt_r[7]) <<< 1;
          end
          2'd1: begin
            c0 = (mt_r[3] - mt_r[8]) <<< 1;
            c1 = ONE_Q - ((mt_r[0] + mt_r[2]) <<< 1);
            c2 = (mt_r[5] + mt_r[6]) <<< 1;
          end
          2'd2: begin
            c0 = (mt_r[4] + mt_r[7]) <<< 1;
            c1 = (mt_r[5] - mt_r[6]) <<< 1;
            c2 = ONE_Q - ((mt_r[0] + mt_r[1]) <<< 1);
          end
          default: begin
            c0 = '0;
            c1 = '0;
            c2 = '0;
          end
        endcase
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.out_real = q_r[0];
          out_data_nxt.out_i = q_r[1];
          out_data_nxt.out_j = q_r[2];
          out_data_nxt.out_k = q_r[3];
          out_data_nxt.row_index = row_r;
          out_data_nxt.col_zero = sat32(c0);
          out_data_nxt.col_one = sat32(c1);
          out_data_nxt.col_two = sat32(c2);
          out_data_nxt.last = (row_r == 2'd2);
          row_nxt = row_r + 2'd1;
          if (row_r == 2'd2) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      thr_r <= 30'd64;
      q_r[0] <= ONE_SAT;
      q_r[1] <= '0;
      q_r[2] <= '0;
      q_r[3] <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      thr_r <= thr_nxt;
      q_r <= q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    cidx_r <= cidx_nxt;
    row_r <= row_nxt;
    kind_r <= kind_nxt;
    opv_r <= opv_nxt;
    scale_r <= scale_nxt;
    acc_r <= acc_nxt;
    mt_r <= mt_nxt;
    prod_r <= prod_nxt;
    sum_r <= sum_nxt;
    sw_r <= sw_nxt;
    sr_r <= sr_nxt;
    bit_r <= bit_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> hw/rtl/qou_checker.sv
// ----------------------------------------------------------------------------
// Quaternion orientation unit checker
// Port-level checks on the item channels and the config port, bound to the top level.
// ----------------------------------------------------------------------------
module qou_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input qou_pkg::out_t out_data,
  input logic          out_valid,
  input logic          out_stall,
  input logic          cfg_ready
);
  import qou_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("unit took an item without going busy");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.row_index != 2'd3)
    else $error("row index out of range");

  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == (out_data.row_index == 2'd2)))
    else $error("last flag does not match row two");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled item changed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind quaternion_orientation_unit qou_checker u_qou_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_data(out_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .cfg_ready(cfg_ready)
);

>>> tb/tb_quaternion_orientation_unit.sv
// ----------------------------------------------------------------------------
// Quaternion orientation unit testbench
// Drives load, multiply, rotate, integrate, normalize, read and unused-kind
// items with random gaps and output stalls, predicts the quaternion and its
// rotation matrix rows, and checks every row item in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class orient_scoreboard;
  localparam int FB = 30;
  logic signed [31:0] q [4];
  logic [29:0] zero_thr;
  qou_pkg::out_t rows_due [$];
  int errors;
  int shown;

  function new();
    errors = 0;
    shown = 0;
    clear();
  endfunction

  function void clear();
    q[0] = 32'sh4000_0000;
    q[1] = 0;
    q[2] = 0;
    q[3] = 0;
    zero_thr = 30'd64;
  endfunction

  function automatic logic signed [31:0] clip(input logic signed [65:0] v);
    if (v > 66'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -66'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [65:0] fmul(input logic signed [65:0] a,
                                               input logic signed [65:0] b);
    logic signed [131:0] p;
    p = a * b;
    return p >>> FB;
  endfunction

  function automatic void ham(input logic signed [65:0] a [4],
                              input logic signed [65:0] b [4],
                              output logic signed [65:0] o [4]);
    o[0] = fmul(a[0], b[0]) - fmul(a[1], b[1]) - fmul(a[2], b[2]) - fmul(a[3], b[3]);
    o[1] = fmul(a[0], b[1]) + fmul(a[1], b[0]) + fmul(a[2], b[3]) - fmul(a[3], b[2]);
    o[2] = fmul(a[0], b[2]) + fmul(a[2], b[0]) + fmul(a[3], b[1]) - fmul(a[1], b[3]);
    o[3] = fmul(a[0], b[3]) + fmul(a[3], b[0]) + fmul(a[1], b[2]) - fmul(a[2], b[1]);
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] s);
    logic [63:0] r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= r + bitv) begin
        s = s - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] ndiv(input logic signed [31:0] c,
                                               input logic [63:0] n);
    logic [127:0] mag, quo;
    logic signed [65:0] r;
    mag = (c < 0) ? -$signed({{96{c[31]}}, c}) : {96'd0, c};
    quo = (mag << FB) / n;
    r = $signed({1'b0, quo[64:0]});
    return clip(c < 0 ? -r : r);
  endfunction

  function void renorm();
    logic [64:0] s;
    logic [63:0] n;
    logic signed [63:0] sq;
    s = 0;
    for (int k = 0; k < 4; k++) begin
      sq = q[k] * q[k];
      s = s + {1'b0, sq};
    end
    if (s[64]) s = 65'h0_FFFF_FFFF_FFFF_FFFF;
    n = isqrt(s[63:0]);
    if ((s[63:0] >> FB) <= {34'd0, zero_thr} || n == 0) begin
      q[0] = 32'sh4000_0000;
      return;
    end
    for (int k = 0; k < 4; k++) q[k] = ndiv(q[k], n);
  endfunction

  function void note_item(input qou_pkg::in_t it);
    logic signed [65:0] a [4], b [4], o [4];
    logic signed [65:0] one, ii, jj, kk, ij, ik, jk, ri, rj, rk;
    logic signed [65:0] m [9];
    qou_pkg::out_t r;
    case (it.kind)
      qou_pkg::K_LOAD: begin
        q[0] = it.op_real; q[1] = it.op_x; q[2] = it.op_y; q[3] = it.op_z;
      end
      qou_pkg::K_MUL, qou_pkg::K_ROT: begin
        for (int k = 0; k < 4; k++) a[k] = q[k];
        b[0] = (it.kind == qou_pkg::K_MUL) ? it.op_real : 0;
        b[1] = it.op_x; b[2] = it.op_y; b[3] = it.op_z;
        ham(a, b, o);
        for (int k = 0; k < 4; k++) q[k] = clip(o[k]);
      end
      qou_pkg::K_INTEG: begin
        for (int k = 0; k < 4; k++) b[k] = q[k];
        a[0] = 0;
        a[1] = clip(fmul(it.op_x, it.step_scale));
        a[2] = clip(fmul(it.op_y, it.step_scale));
        a[3] = clip(fmul(it.op_z, it.step_scale));
        ham(a, b, o);
        for (int k = 0; k < 4; k++) q[k] = clip(b[k] + (o[k] >>> 1));
      end
      qou_pkg::K_NORM: renorm();
      default: ;
    endcase
    one = 66'sd1 << FB;
    ii = fmul(q[1], q[1]); jj = fmul(q[2], q[2]); kk = fmul(q[3], q[3]);
    ij = fmul(q[1], q[2]); ik = fmul(q[1], q[3]); jk = fmul(q[2], q[3]);
    ri = fmul(q[0], q[1]); rj = fmul(q[0], q[2]); rk = fmul(q[0], q[3]);
    m[0] = one - 2 * (jj + kk); m[1] = 2 * (ij + rk); m[2] = 2 * (ik - rj);
    m[3] = 2 * (ij - rk); m[4] = one - 2 * (ii + kk); m[5] = 2 * (jk + ri);
    m[6] = 2 * (ik + rj); m[7] = 2 * (jk - ri); m[8] = one - 2 * (ii + jj);
    for (int k = 0; k < 3; k++) begin
      r.out_real = q[0]; r.out_i = q[1]; r.out_j = q[2]; r.out_k = q[3];
      r.row_index = k[1:0];
      r.col_zero = clip(m[3 * k]);
      r.col_one = clip(m[3 * k + 1]);
      r.col_two = clip(m[3 * k + 2]);
      r.last = (k == 2);
      rows_due.push_back(r);
    end
  endfunction

  function void check_row(input qou_pkg::out_t got);
    qou_pkg::out_t want;
    if (rows_due.size() == 0) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("unexpected row item %h", got);
      end
      return;
    end
    want = rows_due.pop_front();
    if (got !== want) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("row mismatch: expected q=%h %h %h %h r%0d m=%h %h %h l%b",
                 want.out_real, want.out_i, want.out_j, want.out_k, want.row_index,
                 want.col_zero, want.col_one, want.col_two, want.last);
        $display("              actual   q=%h %h %h %h r%0d m=%h %h %h l%b",
                 got.out_real, got.out_i, got.out_j, got.out_k, got.row_index,
                 got.col_zero, got.col_one, got.col_two, got.last);
      end
    end
  endfunction
endclass

module tb_quaternion_orientation_unit;
  import qou_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [29:0] cfg_data = '0;
  bit stall_on = 1'b1;

  orient_scoreboard board = new();

  quaternion_orientation_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] rnd_unit();
    return $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
  endfunction

  task automatic send_item(input in_t it, input bit with_gap);
    int g;
    g = with_gap ? gap_len() : 0;
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(it);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.rows_due.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic write_thr(input logic [29:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.zero_thr = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_op(input logic [2:0] k, input logic signed [31:0] r,
                         input logic signed [31:0] x, input logic signed [31:0] y,
                         input logic signed [31:0] z, input logic signed [31:0] sc);
    in_t it;
    it.kind = k; it.op_real = r; it.op_x = x; it.op_y = y; it.op_z = z;
    it.step_scale = sc;
    send_item(it, 1'b1);
  endtask

  task automatic random_item(input bit unit_range);
    in_t it;
    int p;
    p = $urandom_range(0, 99);
    it.kind = (p < 12) ? K_LOAD : (p < 30) ? K_MUL : (p < 45) ? K_ROT :
              (p < 68) ? K_INTEG : (p < 88) ? K_NORM : 3'($urandom_range(5, 7));
    if (unit_range) begin
      it.op_real = rnd_unit(); it.op_x = rnd_unit(); it.op_y = rnd_unit();
      it.op_z = rnd_unit(); it.step_scale = rnd_unit() >>> $urandom_range(0, 8);
    end else begin
      it.op_real = rnd_word(); it.op_x = rnd_word(); it.op_y = rnd_word();
      it.op_z = rnd_word(); it.step_scale = rnd_word();
    end
    send_item(it, 1'b1);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_row(out_data);
  end

  always @(negedge clk) begin
    if (!stall_on) out_stall <= 1'b0;
    else if (out_stall) out_stall <= ($urandom_range(0, 99) < 70);
    else out_stall <= ($urandom_range(0, 99) < 20);
  end

  initial begin
    #20_000_000;
    $display("quaternion_orientation_unit regression: fail");
    $finish;
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_op(K_READ, 0, 0, 0, 0, 0);
    send_op(K_LOAD, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
    send_op(K_MUL, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 0);
    send_op(K_NORM, 0, 0, 0, 0, 0);
    send_op(K_LOAD, 32'sh4000_0000, 0, 0, 0, 0);
    send_op(K_ROT, 32'sh7FFF_FFFF, 32'sh4000_0000, 0, 0, 0);
    send_op(K_INTEG, 0, 32'sh1000_0000, 32'sh0800_0000, -32'sh0400_0000,
            32'sh0100_0000);
    send_op(K_INTEG, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
            32'sh8000_0000);
    send_op(K_NORM, 0, 0, 0, 0, 0);
    send_op(K_LOAD, 0, 0, 0, 0, 0);
    send_op(K_NORM, 0, 0, 0, 0, 0);
    send_op(K_LOAD, 32'sd8, -32'sd8, 32'sd8, 0, 0);
    send_op(K_NORM, 0, 0, 0, 0, 0);
    send_op(K_LOAD, 32'sh0000_4000, 32'sh0000_4000, 0, 0, 0);
    send_op(K_NORM, 0, 0, 0, 0, 0);
    send_op(K_UNUSED_6, 0, 0, 0, 0, 0);
    send_op(K_UNUSED_7, 0, 0, 0, 0, 0);
    write_thr(30'd0);
    send_op(K_LOAD, 32'sh0000_4000, 32'sh0000_4000, 0, 0, 0);
    send_op(K_NORM, 0, 0, 0, 0, 0);
    write_thr(30'h3FFF_FFFF);
    send_op(K_LOAD, 32'sh4000_0000, 32'sh4000_0000, 0, 0, 0);
    send_op(K_NORM, 0, 0, 0, 0, 0);
    send_op(K_LOAD, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0);
    send_op(K_NORM, 0, 0, 0, 0, 0);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_thr(30'd64);
        1: write_thr(30'($urandom_range(0, 4096)));
        2: write_thr(30'h3FFF_FFFF);
        3: write_thr(30'd0);
        default: write_thr(30'($urandom));
      endcase
      stall_on = (ph != 2);
      for (int n = 0; n < 100; n++) random_item($urandom_range(0, 99) < 75);
    end
    stall_on = 1'b1;

    drain();
    repeat (100) @(negedge clk);
    if (board.errors == 0 && board.rows_due.size() == 0) begin
      $display("quaternion_orientation_unit regression: pass");
    end else begin
      $display("quaternion_orientation_unit regression: fail");
    end
    $finish;
  end
endmodule
